// ===== hdl/palette_index_builder_macros.svh =====
// Assertion macros for the palette index builder
`ifndef PALETTE_INDEX_BUILDER_MACROS_SVH
`define PALETTE_INDEX_BUILDER_MACROS_SVH
`ifndef SYNTHESIS
`define PIB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PIB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`define PIB_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error("assertion failed");
`else
`define PIB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PIB_ASSERT_NEXT(label, clk, rst, ante, cons)
`define PIB_ASSERT_DELAY(label, clk, rst, ante, dly, cons)
`endif
`endif

// ===== hdl/pib_pkg.sv =====
// Shared constants and types for the palette index builder
`timescale 1ns / 1ps
package pib_pkg;
   localparam int PALETTE_DEPTH = 256;
   localparam int BYTE_W        = 8;
   localparam int WORD_W        = 32;
   localparam int PART_W        = 24;
   localparam int INDEX_W       = 8;
   localparam logic [1:0] PHASE_LAST = 2'd3;

   typedef struct packed {
      logic valid;
      logic done;
      logic is_new;
   } ctrl_type;
endpackage

// ===== hdl/pib_pack.sv =====
// Byte packer: gathers four bytes into one pixel word
`timescale 1ns / 1ps
module pib_pack (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_valid,
   input  logic [pib_pkg::BYTE_W-1:0]  byte_data,
   output pib_pkg::ctrl_type           tok_ctrl,
   output logic [pib_pkg::WORD_W-1:0]  tok_word
);
   logic [1:0]                 phase_ff, phase_in;
   logic [pib_pkg::PART_W-1:0] partial_ff, partial_in;
   pib_pkg::ctrl_type          ctrl_ff, ctrl_in;
   logic [pib_pkg::WORD_W-1:0] word_ff, word_in;
   logic                       last;

   assign last = (phase_ff == pib_pkg::PHASE_LAST);

   always_comb begin
      phase_in       = phase_ff;
      partial_in     = partial_ff;
      word_in        = word_ff;
      ctrl_in        = '0;
      if (byte_valid) begin
         if (last) begin
            phase_in      = '0;
            partial_in    = '0;
            word_in       = {partial_ff, byte_data};
            ctrl_in.valid = 1'b1;
         end else begin
            phase_in   = phase_ff + 2'd1;
            partial_in = {partial_ff[pib_pkg::PART_W-pib_pkg::BYTE_W-1:0], byte_data};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         partial_ff <= '0;
         ctrl_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         partial_ff <= partial_in;
         ctrl_ff    <= ctrl_in;
      end
      word_ff <= word_in;
   end

   assign tok_ctrl = ctrl_ff;
   assign tok_word = word_ff;
endmodule

// ===== hdl/pib_cell.sv =====
// Palette cell: holds one colour, matches or claims a passing word
`timescale 1ns / 1ps
module pib_cell #(
   parameter int SLOT    = 0,
   parameter int INDEX_W = pib_pkg::INDEX_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pib_pkg::ctrl_type           in_ctrl,
   input  logic [pib_pkg::WORD_W-1:0]  in_word,
   input  logic [INDEX_W-1:0]          in_idx,
   output pib_pkg::ctrl_type           out_ctrl,
   output logic [pib_pkg::WORD_W-1:0]  out_word,
   output logic [INDEX_W-1:0]          out_idx
);
   logic                       used_ff, used_in;
   logic [pib_pkg::WORD_W-1:0] color_ff, color_in;
   pib_pkg::ctrl_type          ctrl_ff, ctrl_in;
   logic [pib_pkg::WORD_W-1:0] word_ff;
   logic [INDEX_W-1:0]         idx_ff, idx_in;
   logic                       search;

   assign search = in_ctrl.valid && !in_ctrl.done;

   always_comb begin
      used_in  = used_ff;
      color_in = color_ff;
      ctrl_in  = in_ctrl;
      idx_in   = in_idx;
      if (search) begin
         if (!used_ff) begin
            used_in        = 1'b1;
            color_in       = in_word;
            ctrl_in.done   = 1'b1;
            ctrl_in.is_new = 1'b1;
            idx_in         = INDEX_W'(SLOT);
         end else if (color_ff == in_word) begin
            ctrl_in.done = 1'b1;
            idx_in       = INDEX_W'(SLOT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         ctrl_ff <= '0;
      end else begin
         used_ff <= used_in;
         ctrl_ff <= ctrl_in;
      end
      color_ff <= color_in;
      word_ff  <= in_word;
      idx_ff   <= idx_in;
   end

   assign out_ctrl = ctrl_ff;
   assign out_word = word_ff;
   assign out_idx  = idx_ff;
endmodule

// ===== hdl/palette_index_builder.sv =====
// Palette index builder: byte packer followed by a chain of palette cells
// Takes one byte per cycle; busy stays low, so start is always taken.
// A result strobes once the fourth byte of a pixel has passed the packer register
// and the word has walked the chain of palette cells, one register per cell.
// One result per pixel of four bytes; no stall, pixels overlap in the chain.
// Synchronous reset empties the palette and clears the byte phase.
`timescale 1ns / 1ps
`include "palette_index_builder_macros.svh"
module palette_index_builder #(
   parameter int PALETTE_DEPTH = pib_pkg::PALETTE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [pib_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                         rsp_strobe,
   output logic [pib_pkg::INDEX_W-1:0]  rsp_pixel_index,
   output logic                         rsp_is_new,
   output logic                         rsp_palette_full,
   output logic [pib_pkg::WORD_W-1:0]   rsp_pixel_color
);
   localparam int IDX_W = $clog2(PALETTE_DEPTH);

   pib_pkg::ctrl_type          chain_ctrl [0:PALETTE_DEPTH];
   logic [pib_pkg::WORD_W-1:0] chain_word [0:PALETTE_DEPTH];
   logic [IDX_W-1:0]           chain_idx  [0:PALETTE_DEPTH];
   pib_pkg::ctrl_type          last_ctrl;

   assign busy = 1'b0;

   pib_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (start && !busy),
      .byte_data  (req_data_byte),
      .tok_ctrl   (chain_ctrl[0]),
      .tok_word   (chain_word[0])
   );
   assign chain_idx[0] = '0;

   for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
      pib_cell #(
         .SLOT    (k),
         .INDEX_W (IDX_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_ctrl  (chain_ctrl[k]),
         .in_word  (chain_word[k]),
         .in_idx   (chain_idx[k]),
         .out_ctrl (chain_ctrl[k+1]),
         .out_word (chain_word[k+1]),
         .out_idx  (chain_idx[k+1])
      );
   end

   assign last_ctrl        = chain_ctrl[PALETTE_DEPTH];
   assign rsp_strobe       = last_ctrl.valid;
   assign rsp_is_new       = last_ctrl.is_new;
   assign rsp_palette_full = !last_ctrl.done;
   assign rsp_pixel_color  = chain_word[PALETTE_DEPTH];
   assign rsp_pixel_index  = last_ctrl.done ?
                             pib_pkg::INDEX_W'(chain_idx[PALETTE_DEPTH]) : '0;

   `PIB_ASSERT_IMPLY(a_new_not_full, clock, reset, rsp_strobe, !(rsp_is_new && rsp_palette_full))
   `PIB_ASSERT_IMPLY(a_full_zero_index, clock, reset, rsp_strobe && rsp_palette_full, rsp_pixel_index == '0)
   `PIB_ASSERT_DELAY(a_chain_latency, clock, reset, chain_ctrl[0].valid, PALETTE_DEPTH, rsp_strobe)
   `PIB_ASSERT_NEXT(a_result_spacing, clock, reset, rsp_strobe, !rsp_strobe)
endmodule
